FILE: rtl/mcpi_pkg.sv
package mcpi_pkg;

    localparam int TEST_SAMPLES      = 100;
    localparam int HALF_PERIOD_LIMIT = 25;
    localparam int PWM_PERIOD        = 4000;

    localparam int GAIN_W  = 16;
    localparam int AMP_W   = 11;
    localparam int CUR_W   = 12;
    localparam int ERR_W   = CUR_W + 1;
    localparam int INTEG_W = 24;
    localparam int DUTY_W  = 8;
    localparam int CMP_W   = 12;
    localparam int IDX_W   = $clog2(TEST_SAMPLES);
    localparam int HP_W    = $clog2(HALF_PERIOD_LIMIT + 2);

    localparam int DUTY_MAX  = 100;
    localparam int CMP_MAX   = (1 << CMP_W) - 1;
    localparam int MAG_W     = $clog2(DUTY_MAX + 1);
    localparam int AMP_RESET = 200;

    localparam int KP_PROD_W = GAIN_W + 1 + ERR_W;
    localparam int KI_PROD_W = GAIN_W + 1 + INTEG_W;
    localparam int SUM_W     = KI_PROD_W + 1;
    localparam int FRAC_W    = 8;
    localparam int Q_W       = SUM_W - FRAC_W;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = GAIN_W;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 48;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_PWM  = 2'd1,
        MODE_TEST = 2'd2,
        MODE_HOLD = 2'd3
    } mode_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_SET  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN   = 2'd0,
        CFG_KI_GAIN   = 2'd1,
        CFG_AMPLITUDE = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_idx_t;

    typedef logic        [GAIN_W-1:0]  gain_t;
    typedef logic        [AMP_W-1:0]   amp_t;
    typedef logic signed [CUR_W-1:0]   cur_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic signed [INTEG_W-1:0] integ_t;
    typedef logic signed [DUTY_W-1:0]  duty_t;
    typedef logic        [CMP_W-1:0]   cmp_t;
    typedef logic signed [Q_W-1:0]     q_t;
    typedef logic [DUTY_MAX:0][CMP_W-1:0] cmp_table_t;

    function automatic cmp_table_t build_cmp_table();
        cmp_table_t t;
        int         v;
        for (int i = 0; i <= DUTY_MAX; i++)
        begin
            v = PWM_PERIOD * i / DUTY_MAX;
            if (v > CMP_MAX)
            begin
                v = CMP_MAX;
            end
            t[i] = CMP_W'(v);
        end
        return t;
    endfunction

    localparam cmp_table_t CMP_TABLE = build_cmp_table();

    function automatic duty_t clamp_duty(q_t q);
        duty_t d;
        if (q > q_t'(DUTY_MAX))
        begin
            d = duty_t'(DUTY_MAX);
        end
        else if (q < -q_t'(DUTY_MAX))
        begin
            d = -duty_t'(DUTY_MAX);
        end
        else
        begin
            d = duty_t'(q);
        end
        return d;
    endfunction

    function automatic cmp_t duty_to_cmp(duty_t d);
        logic [DUTY_W-1:0] mag;
        mag = d[DUTY_W-1] ? DUTY_W'(-d) : DUTY_W'(d);
        return CMP_TABLE[mag[MAG_W-1:0]];
    endfunction

    function automatic integ_t sat_integ(integ_t i, err_t e);
        logic signed [INTEG_W:0] acc;
        integ_t                  r;
        acc = (INTEG_W+1)'(i) + (INTEG_W+1)'(e);
        if (acc[INTEG_W] != acc[INTEG_W-1])
        begin
            r = acc[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
        end
        else
        begin
            r = acc[INTEG_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/motor_current_pi_loop_top.sv
// channel | direction | transaction fields
// s_*     | in        | tuser: operation; tdata: new_mode, duty_command, sensed_current,
//         |           |   hold_reference
// m_*     | out       | tdata: compare_value, direction_bit, duty_applied, active_mode,
//         |           |   sample_reference, sample_sensed; tlast: test_done; tuser: sample_valid
// cfg_*   | in        | cfg_index, cfg_data; 0 kp_gain, 1 ki_gain, 2 test_amplitude
//
// one transaction per cycle sustained while m_tready is high; each passes the p1, p2 and output registers from s to m
// mode, integrator and test counters update at input acceptance, so ticks chain every cycle
// pi products and the duty scale sit in the two stages that follow
// rst_n resets all control state; cfg_ready is always high
// a stalled m side fills the three stages before s_tready drops
module motor_current_pi_loop_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [1:0] new_mode, [9:2] duty_command, [21:10] sensed_current, [33:22] hold_reference
    input  logic [mcpi_pkg::S_DATA_W-1:0]      s_tdata,
    // [0] operation
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [11:0] compare_value, [12] direction_bit, [20:13] duty_applied, [22:21] active_mode,
    // [34:23] sample_reference, [46:35] sample_sensed
    output logic [mcpi_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tlast,
    // [0] sample_valid
    output logic                               m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mcpi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mcpi_pkg::CFG_W-1:0]         cfg_data
);
    import mcpi_pkg::*;

    typedef struct packed {
        logic  is_pi;
        duty_t duty;
        mode_t mode;
        logic  done;
        logic  smp_valid;
        cur_t  smp_ref;
        cur_t  smp_sen;
    } side_t;

    gain_t  kp_reg, ki_reg;
    amp_t   amp_reg;
    mode_t  mode_reg, mode_next;
    duty_t  duty_hold_reg, duty_hold_next;
    integ_t integ_reg, integ_next;
    cur_t   tref_reg, tref_next;
    logic [HP_W-1:0]  hp_reg, hp_next, hp_eff;
    logic [IDX_W-1:0] idx_reg, idx_next;

    op_t    in_op;
    mode_t  in_mode;
    duty_t  in_duty;
    cur_t   in_sensed, in_hold;
    cur_t   tref_eff, pi_ref;
    err_t   pi_err;
    integ_t pi_integ;
    side_t  side_next;
    logic [IDX_W:0] idx_inc;
    logic   in_fire, cfg_fire;

    logic   p1_valid_reg, p2_valid_reg, out_valid_reg;
    side_t  p1_side_reg, p2_side_reg;
    err_t   p1_err_reg;
    integ_t p1_integ_reg;
    logic   p1_ready, p2_ready, out_ready, adv1, adv2;
    duty_t  mac_duty, fin_duty;

    cmp_t   out_cmp_reg;
    duty_t  out_duty_reg;
    mode_t  out_mode_reg;
    logic   out_done_reg, out_smp_valid_reg;
    cur_t   out_smp_ref_reg, out_smp_sen_reg;

    assign in_op     = op_t'(s_tuser);
    assign in_mode   = mode_t'(s_tdata[1:0]);
    assign in_duty   = s_tdata[9:2];
    assign in_sensed = s_tdata[21:10];
    assign in_hold   = s_tdata[33:22];

    assign out_ready = !out_valid_reg || m_tready;
    assign p2_ready  = !p2_valid_reg || out_ready;
    assign p1_ready  = !p1_valid_reg || p2_ready;
    assign adv2      = p2_valid_reg && out_ready;
    assign adv1      = p1_valid_reg && p2_ready;
    assign s_tready  = p1_ready;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // square-wave flip, then the pi error and integrator
    always_comb
    begin
        if (hp_reg > HP_W'(HALF_PERIOD_LIMIT))
        begin
            tref_eff = -tref_reg;
            hp_eff   = '0;
        end
        else
        begin
            tref_eff = tref_reg;
            hp_eff   = hp_reg;
        end
        pi_ref   = (mode_reg == MODE_TEST) ? tref_eff : in_hold;
        pi_err   = ERR_W'(pi_ref) - ERR_W'(in_sensed);
        pi_integ = sat_integ(integ_reg, pi_err);
        idx_inc  = (IDX_W+1)'(idx_reg) + (IDX_W+1)'(1);
    end

    always_comb
    begin
        mode_next      = mode_reg;
        duty_hold_next = duty_hold_reg;
        integ_next     = integ_reg;
        tref_next      = tref_reg;
        hp_next        = hp_reg;
        idx_next       = idx_reg;
        side_next      = '0;
        if (in_fire)
        begin
            if (in_op == OP_SET)
            begin
                mode_next      = in_mode;
                duty_hold_next = clamp_duty(Q_W'(in_duty));
                side_next.duty = clamp_duty(Q_W'(in_duty));
                side_next.mode = in_mode;
            end
            else
            begin
                side_next.mode = mode_reg;
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        duty_hold_next = '0;
                    end
                    MODE_PWM:
                    begin
                        side_next.duty = duty_hold_reg;
                    end
                    MODE_TEST:
                    begin
                        side_next.is_pi     = 1'b1;
                        side_next.smp_valid = 1'b1;
                        side_next.smp_ref   = tref_eff;
                        side_next.smp_sen   = in_sensed;
                        tref_next           = tref_eff;
                        integ_next          = pi_integ;
                        hp_next             = hp_eff + HP_W'(1);
                        idx_next            = idx_inc[IDX_W-1:0];
                        if (idx_inc >= (IDX_W+1)'(TEST_SAMPLES))
                        begin
                            mode_next      = MODE_IDLE;
                            side_next.mode = MODE_IDLE;
                            side_next.done = 1'b1;
                            idx_next       = '0;
                            integ_next     = '0;
                            hp_next        = '0;
                            tref_next      = CUR_W'(amp_reg);
                        end
                    end
                    MODE_HOLD:
                    begin
                        side_next.is_pi = 1'b1;
                        integ_next      = pi_integ;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
        if (cfg_fire && (cfg_idx_t'(cfg_index) == CFG_AMPLITUDE) && (idx_reg == '0))
        begin
            tref_next = CUR_W'(cfg_data[AMP_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= '0;
            ki_reg        <= '0;
            amp_reg       <= AMP_W'(AMP_RESET);
            mode_reg      <= MODE_IDLE;
            duty_hold_reg <= '0;
            integ_reg     <= '0;
            tref_reg      <= CUR_W'(AMP_RESET);
            hp_reg        <= '0;
            idx_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_KP_GAIN:   kp_reg  <= cfg_data;
                    CFG_KI_GAIN:   ki_reg  <= cfg_data;
                    CFG_AMPLITUDE: amp_reg <= cfg_data[AMP_W-1:0];
                    CFG_UNUSED:    kp_reg  <= kp_reg;
                endcase
            end
            mode_reg      <= mode_next;
            duty_hold_reg <= duty_hold_next;
            integ_reg     <= integ_next;
            tref_reg      <= tref_next;
            hp_reg        <= hp_next;
            idx_reg       <= idx_next;
            p1_valid_reg  <= in_fire || (p1_valid_reg && !p2_ready);
            p2_valid_reg  <= adv1 || (p2_valid_reg && !out_ready);
            out_valid_reg <= adv2 || (out_valid_reg && !m_tready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            p1_side_reg  <= side_next;
            p1_err_reg   <= pi_err;
            p1_integ_reg <= pi_integ;
        end
        if (adv1)
        begin
            p2_side_reg <= p1_side_reg;
        end
        if (adv2)
        begin
            out_cmp_reg       <= duty_to_cmp(fin_duty);
            out_duty_reg      <= fin_duty;
            out_mode_reg      <= p2_side_reg.mode;
            out_done_reg      <= p2_side_reg.done;
            out_smp_valid_reg <= p2_side_reg.smp_valid;
            out_smp_ref_reg   <= p2_side_reg.smp_ref;
            out_smp_sen_reg   <= p2_side_reg.smp_sen;
        end
    end

    mcpi_pi_mac u_mac (
        .clk   (clk),
        .en    (adv1),
        .kp    (kp_reg),
        .ki    (ki_reg),
        .err   (p1_err_reg),
        .integ (p1_integ_reg),
        .duty  (mac_duty)
    );

    assign fin_duty = p2_side_reg.is_pi ? mac_duty : p2_side_reg.duty;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_done_reg;
    assign m_tuser  = out_smp_valid_reg;
    assign m_tdata  = {1'b0, out_smp_sen_reg, out_smp_ref_reg, out_mode_reg, out_duty_reg,
                       out_duty_reg[DUTY_W-1], out_cmp_reg};

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tuser && (out_mode_reg == MODE_IDLE)))
        else $error("test end without sample or idle mode");

    a_hp_range: assert property (@(posedge clk) disable iff (!rst_n)
        hp_reg <= HP_W'(HALF_PERIOD_LIMIT + 1))
        else $error("half-period count out of range");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < IDX_W'(TEST_SAMPLES))
        else $error("sample index out of range");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (p2_valid_reg && !out_ready) |=> p2_valid_reg)
        else $error("stalled pi stage dropped its transaction");

endmodule

FILE: rtl/mcpi_pi_mac.sv
module mcpi_pi_mac (
    input  logic            clk,
    input  logic            en,
    input  mcpi_pkg::gain_t kp,
    input  mcpi_pkg::gain_t ki,
    input  mcpi_pkg::err_t  err,
    input  mcpi_pkg::integ_t integ,
    output mcpi_pkg::duty_t duty
);
    import mcpi_pkg::*;

    logic signed [KP_PROD_W-1:0] kp_prod_reg;
    logic signed [KI_PROD_W-1:0] ki_prod_reg;
    logic signed [SUM_W-1:0]     sum;
    logic signed [SUM_W-1:0]     biased;

    // products registered before the sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kp_prod_reg <= $signed({1'b0, kp}) * err;
            ki_prod_reg <= $signed({1'b0, ki}) * integ;
        end
    end

    // q8.8 scale, truncated toward zero
    always_comb
    begin
        sum    = SUM_W'(kp_prod_reg) + SUM_W'(ki_prod_reg);
        biased = sum + (sum[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : SUM_W'(0));
        duty   = clamp_duty(biased[SUM_W-1:FRAC_W]);
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mcpi_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;
    localparam integ_t INTEG_TOP    = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam integ_t INTEG_BOTTOM = {1'b1, {(INTEG_W-1){1'b0}}};

    typedef struct packed {
        cmp_t  compare;
        logic  negative;
        duty_t duty;
        mode_t mode;
        logic  done;
        logic  sampled;
        cur_t  ref_sample;
        cur_t  sensed_sample;
    } loop_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // loop state as the block should hold it
    gain_t  kp_q88;
    gain_t  ki_q88;
    amp_t   amp_setting;
    mode_t  mode_now;
    duty_t  duty_now;
    integ_t integ_now;
    cur_t   test_ref_now;
    int     half_count;
    int     sample_count;

    loop_result_t loop_results_due[$];

    int  mismatch_count;
    int  items_sent;
    int  results_seen;
    int  reg_writes;
    int  tests_completed;
    int  quiet_cycles;
    int  rx_hold_cycles;
    bit  idling_on;

    motor_current_pi_loop_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic duty_t saturate_duty(longint v);
        if (v > DUTY_MAX)
        begin
            return duty_t'(DUTY_MAX);
        end
        if (v < -DUTY_MAX)
        begin
            return duty_t'(-DUTY_MAX);
        end
        return duty_t'(v);
    endfunction

    function automatic duty_t run_pi(int reference, int sensed);
        int     err;
        longint acc;
        longint sum;
        err = reference - sensed;
        acc = longint'(integ_now) + err;
        if (acc > longint'(INTEG_TOP))
        begin
            acc = longint'(INTEG_TOP);
        end
        if (acc < longint'(INTEG_BOTTOM))
        begin
            acc = longint'(INTEG_BOTTOM);
        end
        integ_now = integ_t'(acc);
        sum = longint'(kp_q88) * err + longint'(ki_q88) * longint'(integ_now);
        return saturate_duty(sum / 256);
    endfunction

    task automatic reset_loop_state();
        kp_q88       = '0;
        ki_q88       = '0;
        amp_setting  = amp_t'(AMP_RESET);
        mode_now     = MODE_IDLE;
        duty_now     = '0;
        integ_now    = '0;
        test_ref_now = cur_t'(AMP_RESET);
        half_count   = 0;
        sample_count = 0;
    endtask

    task automatic record_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
        case (idx)
            CFG_KP_GAIN:
            begin
                kp_q88 = value;
            end
            CFG_KI_GAIN:
            begin
                ki_q88 = value;
            end
            CFG_AMPLITUDE:
            begin
                amp_setting = value[AMP_W-1:0];
                if (sample_count == 0)
                begin
                    test_ref_now = cur_t'({1'b0, amp_setting});
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic step_current_loop(op_t op, mode_t nm, duty_t dc, cur_t sensed, cur_t hold);
        loop_result_t r;
        int           mag;
        int           cmp;
        r = '0;
        if (op == OP_SET)
        begin
            mode_now = nm;
            duty_now = saturate_duty(longint'(dc));
        end
        else
        begin
            case (mode_now)
                MODE_IDLE:
                begin
                    duty_now = '0;
                end
                MODE_PWM:
                begin
                end
                MODE_TEST:
                begin
                    if (half_count > HALF_PERIOD_LIMIT)
                    begin
                        half_count   = 0;
                        test_ref_now = -test_ref_now;
                    end
                    duty_now        = run_pi(int'(test_ref_now), int'(sensed));
                    r.sampled       = 1'b1;
                    r.ref_sample    = test_ref_now;
                    r.sensed_sample = sensed;
                    half_count++;
                    sample_count++;
                    if (sample_count >= TEST_SAMPLES)
                    begin
                        mode_now     = MODE_IDLE;
                        sample_count = 0;
                        integ_now    = '0;
                        half_count   = 0;
                        test_ref_now = cur_t'({1'b0, amp_setting});
                        r.done       = 1'b1;
                        tests_completed++;
                    end
                end
                default:
                begin
                    duty_now = run_pi(int'(hold), int'(sensed));
                end
            endcase
        end
        mag = int'(duty_now);
        if (mag < 0)
        begin
            mag = -mag;
        end
        cmp = PWM_PERIOD * mag / DUTY_MAX;
        if (cmp > CMP_MAX)
        begin
            cmp = CMP_MAX;
        end
        r.compare  = cmp_t'(cmp);
        r.negative = (duty_now < 0);
        r.duty     = duty_now;
        r.mode     = mode_now;
        loop_results_due.push_back(r);
    endtask

    function automatic cur_t any_current();
        return cur_t'($urandom);
    endfunction

    function automatic duty_t any_duty();
        return duty_t'($urandom);
    endfunction

    function automatic mode_t any_mode();
        return mode_t'(2'($urandom_range(0, 3)));
    endfunction

    function automatic cur_t near(int target);
        int v;
        v = target + $urandom_range(0, 200) - 100;
        if (v > 2047)
        begin
            v = 2047;
        end
        if (v < -2048)
        begin
            v = -2048;
        end
        return cur_t'(v);
    endfunction

    function automatic gain_t pick_gain();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return gain_t'($urandom_range(0, 400));
            default: return gain_t'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_amplitude();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    task automatic send_item(op_t op, mode_t nm, duty_t dc, cur_t sensed, cur_t hold);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_DATA_W'({hold, sensed, dc, nm});
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        step_current_loop(op, nm, dc, sensed, hold);
        items_sent++;
    endtask

    task automatic send_set(mode_t nm, duty_t dc);
        send_item(OP_SET, nm, dc, any_current(), any_current());
    endtask

    task automatic send_tick(cur_t sensed, cur_t hold);
        send_item(OP_TICK, any_mode(), any_duty(), sensed, hold);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        record_register(idx, value);
        reg_writes++;
    endtask

    task automatic configure(gain_t kp, gain_t ki, logic [CFG_W-1:0] amp);
        write_register(CFG_KP_GAIN, kp);
        write_register(CFG_KI_GAIN, ki);
        write_register(CFG_AMPLITUDE, amp);
        write_register(CFG_UNUSED, CFG_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (loop_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic void check_field(string name, int want, int seen);
        if (want != seen)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
            begin
                $display("mismatch on result %0d, %s: expected %0d, got %0d",
                         results_seen, name, want, seen);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        loop_result_t want;
        loop_result_t got;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            got.compare       = m_tdata[11:0];
            got.negative      = m_tdata[12];
            got.duty          = m_tdata[20:13];
            got.mode          = mode_t'(m_tdata[22:21]);
            got.ref_sample    = m_tdata[34:23];
            got.sensed_sample = m_tdata[46:35];
            got.done          = m_tlast;
            got.sampled       = m_tuser;
            if (loop_results_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("unexpected result transaction: %h", m_tdata);
                end
            end
            else
            begin
                want = loop_results_due.pop_front();
                check_field("compare_value", int'(want.compare), int'(got.compare));
                check_field("direction_bit", int'(want.negative), int'(got.negative));
                check_field("duty_applied", int'(want.duty), int'(got.duty));
                check_field("active_mode", int'(want.mode), int'(got.mode));
                check_field("test_done", int'(want.done), int'(got.done));
                check_field("sample_valid", int'(want.sampled), int'(got.sampled));
                check_field("sample_reference", int'(want.ref_sample),
                            int'(got.ref_sample));
                check_field("sample_sensed", int'(want.sensed_sample),
                            int'(got.sensed_sample));
            end
            results_seen++;
        end
    end

    initial
    begin
        int rx_burst;
        rx_burst = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (rx_burst > 0)
            begin
                m_tready <= 1'b0;
                rx_burst--;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                rx_burst = $urandom_range(1, 11) - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1)
            || (cfg_valid === 1'b1 && cfg_ready === 1'b1))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, loop_results_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_idle_after_reset();
        send_tick(cur_t'(-2048), cur_t'(2047));
        send_tick(cur_t'(2047), cur_t'(-2048));
        send_tick(cur_t'(0), cur_t'(0));
        send_set(MODE_TEST, any_duty());
        send_tick(cur_t'(-2048), any_current());
        send_tick(cur_t'(2047), any_current());
        send_set(MODE_IDLE, duty_t'(0));
    endtask

    task automatic test_open_loop_pwm();
        send_set(MODE_PWM, duty_t'(127));
        send_tick(any_current(), any_current());
        send_set(MODE_PWM, duty_t'(-128));
        send_tick(any_current(), any_current());
        send_set(MODE_PWM, duty_t'(-100));
        send_set(MODE_PWM, duty_t'(100));
        send_set(MODE_PWM, duty_t'(-1));
        send_tick(any_current(), any_current());
        send_set(MODE_IDLE, duty_t'(55));
        send_tick(any_current(), any_current());
    endtask

    task automatic test_hold_extremes();
        settle();
        configure('1, '1, '1);
        send_set(MODE_HOLD, duty_t'(0));
        send_tick(cur_t'(-2048), cur_t'(2047));
        send_tick(cur_t'(2047), cur_t'(-2048));
        send_tick(cur_t'(5), cur_t'(5));
        settle();
        configure('0, '0, '0);
        send_set(MODE_TEST, duty_t'(0));
        send_tick(any_current(), any_current());
        send_tick(any_current(), any_current());
    endtask

    task automatic test_full_current_test();
        int n;
        settle();
        configure(16'd256, 16'd4, 16'd1500);
        send_set(MODE_TEST, duty_t'(0));
        n = TEST_SAMPLES - sample_count;
        repeat (n) send_tick(near(int'(test_ref_now)), any_current());
        send_tick(any_current(), any_current());
    endtask

    task automatic test_integrator_swing();
        settle();
        configure('0, 16'd1, 16'd300);
        send_set(MODE_HOLD, duty_t'(0));
        repeat (20) send_tick(cur_t'(-2048), cur_t'(2047));
        repeat (40) send_tick(cur_t'(2047), cur_t'(-2048));
        send_set(MODE_IDLE, duty_t'(0));
    endtask

    task automatic test_random_traffic(int target);
        int   start;
        int   seq_no;
        int   kind;
        int   n;
        cur_t r;
        start     = items_sent;
        seq_no    = 0;
        idling_on = 1'b1;
        while (items_sent - start < target)
        begin
            if (seq_no % 6 == 5)
            begin
                settle();
                configure(pick_gain(), pick_gain(), pick_amplitude());
            end
            seq_no++;
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                send_set(MODE_TEST, any_duty());
                n = TEST_SAMPLES - sample_count;
                if ($urandom_range(0, 3) == 0)
                begin
                    n = $urandom_range(1, n);
                end
                repeat (n) send_tick(near(int'(test_ref_now)), any_current());
            end
            else if (kind < 65)
            begin
                r = any_current();
                send_set(MODE_HOLD, any_duty());
                repeat ($urandom_range(5, 30))
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        r = any_current();
                    end
                    send_tick(near(int'(r)), r);
                end
            end
            else if (kind < 80)
            begin
                send_set(MODE_PWM, any_duty());
                repeat ($urandom_range(1, 5)) send_tick(any_current(), any_current());
            end
            else if (kind < 88)
            begin
                send_set(MODE_IDLE, any_duty());
                repeat ($urandom_range(1, 3)) send_tick(any_current(), any_current());
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    send_item(op_t'($urandom_range(0, 1)), any_mode(), any_duty(),
                              any_current(), any_current());
                end
            end
        end
    endtask

    task automatic test_backpressure();
        settle();
        idling_on      = 1'b0;
        rx_hold_cycles = 150;
        send_set(MODE_HOLD, duty_t'(0));
        repeat (40) send_tick(any_current(), any_current());
        settle();
    endtask

    task automatic test_quiet_finish();
        idling_on = 1'b0;
        configure(pick_gain(), pick_gain(), pick_amplitude());
        send_set(MODE_TEST, any_duty());
        repeat (30) send_tick(near(int'(test_ref_now)), any_current());
        repeat (30)
        begin
            send_item(op_t'($urandom_range(0, 1)), any_mode(), any_duty(),
                      any_current(), any_current());
        end
        settle();
    endtask

    initial
    begin
        idling_on      = 1'b1;
        rx_hold_cycles = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_TICK;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_KP_GAIN;
        cfg_data  <= '0;
        reset_loop_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_after_reset();
        test_open_loop_pwm();
        test_hold_extremes();
        test_full_current_test();
        test_integrator_swing();
        test_random_traffic(380);
        test_backpressure();
        test_quiet_finish();

        $display("run: %0d input transactions, %0d results checked, %0d register writes",
                 items_sent, results_seen, reg_writes);
        $display("run: %0d current tests completed, integrator driven hard both ways, %0d mismatches",
                 tests_completed, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
